### hdl/mse_pkg.sv
// Package with the shared types, opcodes and constants of the MIPS subset execute block.
`timescale 1ns / 1ps

package mse_pkg;

	localparam int PROGRAM_DEPTH_DEF = 1024;
	localparam int NUM_REGS = 32;
	localparam int REG_AW = 5;
	localparam int LEN_W = 11;
	localparam int NPC_W = 10;

	localparam logic [10:0] PROGRAM_LENGTH_RST = 11'd1024;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_BEQ = 6'h04;
	localparam logic [5:0] OP_BNE = 6'h05;
	localparam logic [5:0] OP_ADDI = 6'h08;
	localparam logic [5:0] OP_SLTI = 6'h0a;
	localparam logic [5:0] OP_ANDI = 6'h0c;
	localparam logic [5:0] OP_ORI = 6'h0d;
	localparam logic [5:0] OP_LUI = 6'h0f;
	localparam logic [5:0] OP_SPECIAL2 = 6'h1c;

	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR = 6'h25;
	localparam logic [5:0] FN_SLT = 6'h2a;

	localparam logic [10:0] MUL_LOW_BITS = 11'h002;
	localparam logic [31:0] SYSCALL_WORD = 32'h0000000c;

	localparam logic [31:0] SYS_PRINT_INT = 32'd1;
	localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;
	localparam logic [31:0] SYS_EXIT = 32'd10;

	localparam logic [REG_AW-1:0] REG_V0 = 5'd2;
	localparam logic [REG_AW-1:0] REG_A0 = 5'd4;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_PRINT_INT = 3'd1,
		ST_PRINT_CHAR = 3'd2,
		ST_EXIT = 3'd3,
		ST_UNKNOWN_SYS = 3'd4,
		ST_INVALID = 3'd5,
		ST_HALTED = 3'd6,
		ST_PC_OUT = 3'd7
	} status_t;

	typedef struct packed {
		logic en;
		logic [REG_AW-1:0] addr;
		logic [31:0] data;
	} rf_wr_t;

	typedef struct packed {
		status_t status;
		logic [31:0] value;
		rf_wr_t wr;
		logic halt;
		logic pc_load;
	} exec_res_t;

endpackage

### hdl/mse_if.sv
// Interfaces for the instruction channel and the result channel.
`timescale 1ns / 1ps

interface mse_cmd_if;
	logic valid;
	logic ready;
	logic mode;
	logic [31:0] instruction_word;
	logic [4:0] reg_index;

	modport source(output valid, mode, instruction_word, reg_index, input ready);
	modport sink(input valid, mode, instruction_word, reg_index, output ready);
endinterface

interface mse_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic signed [31:0] out_value;
	logic [9:0] next_pc;

	modport source(output valid, status, out_value, next_pc, input ready);
	modport sink(input valid, status, out_value, next_pc, output ready);
endinterface

### hdl/mips_subset_instruction_execute.sv
// Top level of the MIPS subset execute block: input stage, register file, execute and result register.
// The cmd channel carries one transaction per instruction (mode 0) or register read
// (mode 1); the rsp channel returns exactly one transaction for each, in order.
// A transaction accepted at a clock edge is held in the input stage and the register file read
// registers, then executed and its result registered in the result register that drives rsp.
// Throughput is one transaction per cycle when rsp is not stalled: the register file reads rs
// and rt at the accepting edge, and a one-entry bypass covers the write that lands at that same edge.
// Execute, including the 32 by 32 multiply, fits the single stage before the result
// register.
// When rsp stalls, the result register holds and one more transaction can wait in the
// input stage; cmd ready drops only when both are full.
// Reset clears all registers to zero, the program counter to zero, the halt flag, and sets
// program_length to 1024. program_length is written through cfg_we and cfg_wdata; the user
// must do so only while no transaction is in flight, which the block itself does not enforce.
// Once halted, execute transactions return status 6 and register reads still work.
`timescale 1ns / 1ps

module mips_subset_instruction_execute #(
	parameter int PROGRAM_DEPTH = mse_pkg::PROGRAM_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mse_cmd_if.sink cmd,
	mse_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic [mse_pkg::LEN_W-1:0] cfg_wdata
);
	import mse_pkg::*;

	localparam int PC_W = $clog2(PROGRAM_DEPTH);

	logic [LEN_W-1:0] prog_len_q;
	logic [PC_W-1:0] pc_q;
	logic halted_q;
	logic s1_valid_q;
	logic mode_s1;
	logic [31:0] instr_s1;
	logic out_valid_q;
	status_t status_q;
	logic [31:0] value_q;
	logic [NPC_W-1:0] npc_q;

	logic out_free;
	logic s1_fire;
	logic accept;
	logic [REG_AW-1:0] rd_addr_a;
	logic [31:0] rs_val;
	logic [31:0] rt_val;
	logic [31:0] v0;
	logic [31:0] a0;
	logic [31:0] lim;
	logic [PC_W-1:0] pc_next;
	logic [PC_W-1:0] pc_after;
	logic [31:0] pc_after_ext;
	exec_res_t res;
	rf_wr_t rf_wr;

	assign out_free = !out_valid_q || rsp.ready;
	assign s1_fire = s1_valid_q && out_free;
	assign cmd.ready = !s1_valid_q || out_free;
	assign accept = cmd.valid && cmd.ready;

	assign rd_addr_a = cmd.mode ? cmd.reg_index : cmd.instruction_word[25:21];
	assign lim = (32'(prog_len_q) > 32'(PROGRAM_DEPTH)) ? 32'(PROGRAM_DEPTH) : 32'(prog_len_q);

	always_comb begin
		rf_wr = res.wr;
		rf_wr.en = res.wr.en && s1_fire;
	end

	mse_regfile u_regfile (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(cmd.instruction_word[20:16]),
		.wr(rf_wr),
		.rd_data_a(rs_val),
		.rd_data_b(rt_val),
		.v0(v0),
		.a0(a0)
	);

	mse_exec #(
		.PC_W(PC_W)
	) u_exec (
		.mode(mode_s1),
		.instr(instr_s1),
		.rs_val(rs_val),
		.rt_val(rt_val),
		.v0(v0),
		.a0(a0),
		.pc(pc_q),
		.halted(halted_q),
		.lim(lim),
		.res(res),
		.pc_next(pc_next)
	);

	assign pc_after = res.pc_load ? pc_next : pc_q;
	assign pc_after_ext = 32'(pc_after);

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= cmd.mode;
			instr_s1 <= cmd.instruction_word;
		end
		if (s1_fire) begin
			value_q <= res.value;
			npc_q <= pc_after_ext[NPC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q <= PROGRAM_LENGTH_RST;
			pc_q <= '0;
			halted_q <= 1'b0;
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				prog_len_q <= cfg_wdata;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
				status_q <= res.status;
				pc_q <= pc_after;
				if (res.halt) begin
					halted_q <= 1'b1;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.out_value = value_q;
	assign rsp.next_pc = npc_q;

`ifndef SYNTH
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> out_valid_q)
		else $error("execute stage fired without a result being registered");

	a_halted_status: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && halted_q && !mode_s1) |=> (status_q == ST_HALTED))
		else $error("execute while halted did not report the halted status");

	a_halted_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !rf_wr.en)
		else $error("register file written while halted");

	a_halted_pc_stable: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> $stable(pc_q))
		else $error("program counter moved while halted");
`endif

endmodule

### hdl/mse_regfile.sv
// Register file with two registered read ports, write bypass and shadow copies of $v0 and $a0.
`timescale 1ns / 1ps

module mse_regfile (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [mse_pkg::REG_AW-1:0] rd_addr_a,
	input  logic [mse_pkg::REG_AW-1:0] rd_addr_b,
	input  mse_pkg::rf_wr_t wr,
	output logic [31:0] rd_data_a,
	output logic [31:0] rd_data_b,
	output logic [31:0] v0,
	output logic [31:0] a0
);
	import mse_pkg::*;

	logic [31:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [31:0] data_a_q;
	logic [31:0] data_b_q;
	logic [31:0] byp_data_q;
	logic va_q;
	logic vb_q;
	logic hit_a_q;
	logic hit_b_q;
	logic [31:0] v0_q;
	logic [31:0] a0_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_a_q <= mem[rd_addr_a];
			data_b_q <= mem[rd_addr_b];
			byp_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q <= 1'b0;
			vb_q <= 1'b0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
			v0_q <= '0;
			a0_q <= '0;
		end else begin
			if (rd_en) begin
				va_q <= valid_q[rd_addr_a];
				vb_q <= valid_q[rd_addr_b];
				hit_a_q <= wr.en && (wr.addr == rd_addr_a);
				hit_b_q <= wr.en && (wr.addr == rd_addr_b);
			end
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
				if (wr.addr == REG_V0) begin
					v0_q <= wr.data;
				end
				if (wr.addr == REG_A0) begin
					a0_q <= wr.data;
				end
			end
		end
	end

	assign rd_data_a = hit_a_q ? byp_data_q : (va_q ? data_a_q : '0);
	assign rd_data_b = hit_b_q ? byp_data_q : (vb_q ? data_b_q : '0);
	assign v0 = v0_q;
	assign a0 = a0_q;

endmodule

### hdl/mse_exec.sv
// Decode, ALU, branch target and status logic for one instruction or register read.
`timescale 1ns / 1ps

module mse_exec #(
	parameter int PC_W = 10
) (
	input  logic mode,
	input  logic [31:0] instr,
	input  logic [31:0] rs_val,
	input  logic [31:0] rt_val,
	input  logic [31:0] v0,
	input  logic [31:0] a0,
	input  logic [PC_W-1:0] pc,
	input  logic halted,
	input  logic [31:0] lim,
	output mse_pkg::exec_res_t res,
	output logic [PC_W-1:0] pc_next
);
	import mse_pkg::*;

	logic [5:0] op;
	logic [REG_AW-1:0] rt;
	logic [REG_AW-1:0] rd;
	logic [4:0] shamt;
	logic [5:0] funct;
	logic [15:0] imm;
	logic [31:0] simm;
	logic [31:0] zimm;
	logic enc_ok;
	logic is_sys;
	logic br_taken;
	logic w_en;
	logic [REG_AW-1:0] w_addr;
	logic [31:0] w_data;
	logic [31:0] pc_ext;
	logic signed [33:0] step_s;
	logic signed [33:0] next_s;
	logic next_oob;

	assign op = instr[31:26];
	assign rt = instr[20:16];
	assign rd = instr[15:11];
	assign shamt = instr[10:6];
	assign funct = instr[5:0];
	assign imm = instr[15:0];
	assign simm = {{16{imm[15]}}, imm};
	assign zimm = {16'b0, imm};

	always_comb begin
		enc_ok = 1'b1;
		is_sys = 1'b0;
		br_taken = 1'b0;
		w_en = 1'b0;
		w_addr = rt;
		w_data = '0;
		unique case (op)
			OP_SPECIAL: begin
				w_addr = rd;
				if (instr == SYSCALL_WORD) begin
					is_sys = 1'b1;
				end else if (shamt != '0) begin
					enc_ok = 1'b0;
				end else begin
					w_en = 1'b1;
					unique case (funct)
						FN_ADD: w_data = rs_val + rt_val;
						FN_SUB: w_data = rs_val - rt_val;
						FN_AND: w_data = rs_val & rt_val;
						FN_OR: w_data = rs_val | rt_val;
						FN_SLT: w_data = {31'b0, $signed(rs_val) < $signed(rt_val)};
						default: begin
							enc_ok = 1'b0;
							w_en = 1'b0;
						end
					endcase
				end
			end
			OP_SPECIAL2: begin
				w_addr = rd;
				if (instr[10:0] != MUL_LOW_BITS) begin
					enc_ok = 1'b0;
				end else begin
					w_en = 1'b1;
					w_data = rs_val * rt_val;
				end
			end
			OP_BEQ: br_taken = (rs_val == rt_val);
			OP_BNE: br_taken = (rs_val != rt_val);
			OP_ADDI: begin
				w_en = 1'b1;
				w_data = rs_val + simm;
			end
			OP_SLTI: begin
				w_en = 1'b1;
				w_data = {31'b0, $signed(rs_val) < $signed(simm)};
			end
			OP_ANDI: begin
				w_en = 1'b1;
				w_data = rs_val & zimm;
			end
			OP_ORI: begin
				w_en = 1'b1;
				w_data = rs_val | zimm;
			end
			OP_LUI: begin
				if (instr[25:21] != '0) begin
					enc_ok = 1'b0;
				end else begin
					w_en = 1'b1;
					w_data = {imm, 16'b0};
				end
			end
			default: enc_ok = 1'b0;
		endcase
	end

	assign pc_ext = 32'(pc);
	assign step_s = br_taken ? 34'(signed'(imm)) : 34'sd1;
	assign next_s = $signed({2'b00, pc_ext}) + step_s;
	assign next_oob = next_s[33] || (next_s >= $signed({2'b00, lim}));
	assign pc_next = next_s[PC_W-1:0];

	always_comb begin
		res = '0;
		res.status = ST_OK;
		if (mode) begin
			res.value = rs_val;
		end else if (halted) begin
			res.status = ST_HALTED;
		end else if (pc_ext >= lim) begin
			res.status = ST_PC_OUT;
			res.halt = 1'b1;
		end else if (!enc_ok) begin
			res.status = ST_INVALID;
			res.halt = 1'b1;
		end else if (is_sys && (v0 == SYS_EXIT)) begin
			res.status = ST_EXIT;
			res.halt = 1'b1;
		end else if (is_sys && (v0 != SYS_PRINT_INT) && (v0 != SYS_PRINT_CHAR)) begin
			res.status = ST_UNKNOWN_SYS;
			res.value = v0;
			res.halt = 1'b1;
		end else begin
			res.wr.en = w_en && (w_addr != '0);
			res.wr.addr = w_addr;
			res.wr.data = w_data;
			if (is_sys && (v0 == SYS_PRINT_INT)) begin
				res.status = ST_PRINT_INT;
				res.value = a0;
			end else if (is_sys) begin
				res.status = ST_PRINT_CHAR;
				res.value = {24'b0, a0[7:0]};
			end else if (next_oob) begin
				res.status = ST_PC_OUT;
			end
			res.halt = next_oob;
			res.pc_load = !next_oob;
		end
	end

endmodule

### sim/mips_subset_instruction_execute_tb.sv
// Self-checking testbench for the MIPS subset execute block with a predicting scoreboard.
`timescale 1ns / 1ps

module mips_subset_instruction_execute_tb;
	import mse_pkg::*;

	typedef enum logic {
		MODE_EXEC = 1'b0,
		MODE_READ = 1'b1
	} cmd_mode_t;

	typedef enum int {
		HALT_EXIT,
		HALT_UNKNOWN_SYS,
		HALT_INVALID,
		HALT_BRANCH_OUT,
		HALT_FALL_OFF,
		HALT_PRINT_AT_END,
		HALT_PAST_LIMIT,
		HALT_ZERO_LENGTH
	} halt_kind_t;

	class exec_scoreboard;
		typedef struct {
			status_t status;
			logic [31:0] value;
			logic [9:0] npc;
		} outcome_t;

		logic [31:0] regs [32];
		int pc;
		logic halted;
		logic [10:0] prog_len;
		outcome_t pending_outcomes[$];
		int errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			pc = 0;
			halted = 1'b0;
			prog_len = PROGRAM_LENGTH_RST;
			errors = 0;
		endfunction

		function int limit();
			return (prog_len > PROGRAM_DEPTH_DEF) ? PROGRAM_DEPTH_DEF : int'(prog_len);
		endfunction

		function outcome_t execute_step(cmd_mode_t m, logic [31:0] w, logic [4:0] ri);
			outcome_t o;
			logic [5:0] op;
			logic [4:0] rs, rt, rd, wa;
			logic [31:0] a, b, sx, wd;
			logic wen, bad;
			int lim, nxt;
			o.status = ST_OK;
			o.value = '0;
			lim = limit();
			if (m == MODE_READ) begin
				o.value = regs[ri];
			end else if (halted) begin
				o.status = ST_HALTED;
			end else if (pc >= lim) begin
				halted = 1'b1;
				o.status = ST_PC_OUT;
			end else begin
				op = w[31:26];
				rs = w[25:21];
				rt = w[20:16];
				rd = w[15:11];
				a = regs[rs];
				b = regs[rt];
				sx = {{16{w[15]}}, w[15:0]};
				nxt = pc + 1;
				wen = 1'b0;
				wa = rt;
				wd = '0;
				bad = 1'b0;
				if (w == SYSCALL_WORD) begin
					if (regs[REG_V0] == SYS_PRINT_INT) begin
						o.status = ST_PRINT_INT;
						o.value = regs[REG_A0];
					end else if (regs[REG_V0] == SYS_PRINT_CHAR) begin
						o.status = ST_PRINT_CHAR;
						o.value = {24'h0, regs[REG_A0][7:0]};
					end else if (regs[REG_V0] == SYS_EXIT) begin
						o.status = ST_EXIT;
						halted = 1'b1;
					end else begin
						o.status = ST_UNKNOWN_SYS;
						o.value = regs[REG_V0];
						halted = 1'b1;
					end
				end else begin
					case (op)
						OP_SPECIAL: begin
							wen = 1'b1;
							wa = rd;
							if (w[10:6] != 5'd0) bad = 1'b1;
							else case (w[5:0])
								FN_ADD: wd = a + b;
								FN_SUB: wd = a - b;
								FN_AND: wd = a & b;
								FN_OR: wd = a | b;
								FN_SLT: wd = {31'd0, $signed(a) < $signed(b)};
								default: bad = 1'b1;
							endcase
						end
						OP_SPECIAL2: begin
							wen = 1'b1;
							wa = rd;
							if (w[10:0] != MUL_LOW_BITS) bad = 1'b1;
							else wd = a * b;
						end
						OP_BEQ, OP_BNE: begin
							if ((op == OP_BEQ) == (a == b)) nxt = pc + $signed(w[15:0]);
						end
						OP_ADDI: begin
							wen = 1'b1;
							wd = a + sx;
						end
						OP_SLTI: begin
							wen = 1'b1;
							wd = {31'd0, $signed(a) < $signed(sx)};
						end
						OP_ANDI: begin
							wen = 1'b1;
							wd = a & {16'd0, w[15:0]};
						end
						OP_ORI: begin
							wen = 1'b1;
							wd = a | {16'd0, w[15:0]};
						end
						OP_LUI: begin
							wen = 1'b1;
							if (rs != 5'd0) bad = 1'b1;
							else wd = {w[15:0], 16'd0};
						end
						default: bad = 1'b1;
					endcase
				end
				if (bad) begin
					halted = 1'b1;
					o.status = ST_INVALID;
				end else if (!halted) begin
					if (wen && wa != 5'd0) regs[wa] = wd;
					if (nxt < 0 || nxt >= lim) begin
						halted = 1'b1;
						if (o.status == ST_OK) o.status = ST_PC_OUT;
					end else begin
						pc = nxt;
					end
				end
			end
			o.npc = pc[9:0];
			return o;
		endfunction

		function void note_command(cmd_mode_t m, logic [31:0] w, logic [4:0] ri);
			pending_outcomes.push_back(execute_step(m, w, ri));
		endfunction

		function void check_response(logic [2:0] st, logic [31:0] val, logic [9:0] npc);
			outcome_t exp_o;
			if (pending_outcomes.size() == 0) begin
				$error("response with no transaction pending: status %0d", st);
				errors++;
				return;
			end
			exp_o = pending_outcomes.pop_front();
			if (st !== exp_o.status) begin
				$error("status mismatch: expected %0d, actual %0d", exp_o.status, st);
				errors++;
			end
			if (val !== exp_o.value) begin
				$error("out_value mismatch: expected %h, actual %h", exp_o.value, val);
				errors++;
			end
			if (npc !== exp_o.npc) begin
				$error("next_pc mismatch: expected %0d, actual %0d", exp_o.npc, npc);
				errors++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;
	logic no_idle;
	int cycle_count;
	exec_scoreboard sb;

	mse_cmd_if cmd_bus();
	mse_rsp_if rsp_bus();

	mips_subset_instruction_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.rsp(rsp_bus),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		rsp_bus.ready <= arst_n && (no_idle || ($urandom_range(99) >= 15));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (rsp_bus.valid && rsp_bus.ready)
			sb.check_response(rsp_bus.status, rsp_bus.out_value, rsp_bus.next_pc);
		if (cycle_count == CYCLE_LIMIT) begin
			$display("mips_subset_instruction_execute_tb: FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd);
		return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
	endfunction

	function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] mul_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd);
		return {OP_SPECIAL2, rs, rt, rd, MUL_LOW_BITS};
	endfunction

	function automatic logic [5:0] any_alu_funct();
		case ($urandom_range(4))
			0: return FN_ADD;
			1: return FN_SUB;
			2: return FN_AND;
			3: return FN_OR;
			default: return FN_SLT;
		endcase
	endfunction

	function automatic logic [15:0] random_imm();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h7fff;
			3: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Picks an instruction whose next pc stays inside the program, so the core keeps running.
	function automatic logic [31:0] random_instruction();
		int lim, target, lo, hi, kind;
		logic [4:0] rs, rt, rd;
		logic [5:0] op;
		logic [15:0] imm;
		logic taken;
		lim = sb.limit();
		rs = 5'($urandom_range(31));
		rt = 5'($urandom_range(31));
		rd = 5'($urandom_range(31));
		imm = random_imm();
		kind = (sb.pc + 1 >= lim) ? 99 : $urandom_range(99);
		if (kind < 30) return r_word(any_alu_funct(), rs, rt, rd);
		if (kind < 38) return mul_word(rs, rt, rd);
		if (kind < 70) begin
			case ($urandom_range(4))
				0: op = OP_ADDI;
				1: op = OP_SLTI;
				2: op = OP_ANDI;
				3: op = OP_ORI;
				default: begin
					op = OP_LUI;
					rs = 5'd0;
				end
			endcase
			return i_word(op, rs, rt, imm);
		end
		if (kind < 80) begin
			if (sb.regs[REG_V0] == SYS_PRINT_INT || sb.regs[REG_V0] == SYS_PRINT_CHAR)
				return SYSCALL_WORD;
			return i_word(OP_ORI, 5'd0, REG_V0,
				$urandom_range(1) ? SYS_PRINT_INT[15:0] : SYS_PRINT_CHAR[15:0]);
		end
		op = $urandom_range(1) ? OP_BEQ : OP_BNE;
		if ($urandom_range(9) < 3) rt = rs;
		taken = ((op == OP_BEQ) == (sb.regs[rs] == sb.regs[rt]));
		if (!taken && sb.pc + 1 >= lim) begin
			op = OP_BEQ;
			rt = rs;
			taken = 1'b1;
		end
		if (taken) begin
			if ($urandom_range(1)) begin
				target = $urandom_range(lim - 1);
			end else begin
				lo = (sb.pc > 8) ? sb.pc - 8 : 0;
				hi = (sb.pc + 8 < lim) ? sb.pc + 8 : lim - 1;
				target = $urandom_range(hi, lo);
			end
			imm = 16'(target - sb.pc);
		end
		return i_word(op, rs, rt, imm);
	endfunction

	task automatic send_command(input cmd_mode_t m, input logic [31:0] w,
			input logic [4:0] ri);
		if (!no_idle && $urandom_range(99) < 7) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.mode <= m;
		cmd_bus.instruction_word <= w;
		cmd_bus.reg_index <= ri;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		sb.note_command(m, w, ri);
	endtask

	task automatic exec(input logic [31:0] w);
		send_command(MODE_EXEC, w, 5'($urandom_range(31)));
	endtask

	task automatic read_reg(input logic [4:0] idx);
		send_command(MODE_READ, $urandom(), idx);
	endtask

	task automatic go_to_start();
		logic [15:0] back;
		back = 16'(-sb.pc);
		exec(i_word(OP_BEQ, 5'd0, 5'd0, back));
	endtask

	task automatic write_length(input logic [LEN_W-1:0] len);
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_outcomes.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.prog_len = len;
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 15) read_reg(5'($urandom_range(31)));
			else exec(random_instruction());
		end
	endtask

	task automatic directed_items();
		send_command(MODE_READ, 32'hffff_ffff, 5'd0);
		send_command(MODE_READ, 32'h0000_0000, 5'd31);
		exec(i_word(OP_LUI, 5'd0, 5'd1, 16'hffff));
		exec(i_word(OP_ORI, 5'd1, 5'd1, 16'hffff));
		exec(i_word(OP_LUI, 5'd0, 5'd3, 16'h7fff));
		exec(i_word(OP_ORI, 5'd3, 5'd3, 16'hffff));
		exec(r_word(FN_ADD, 5'd3, 5'd3, 5'd5));
		exec(r_word(FN_SUB, 5'd1, 5'd3, 5'd6));
		exec(r_word(FN_AND, 5'd1, 5'd3, 5'd7));
		exec(r_word(FN_OR, 5'd5, 5'd0, 5'd8));
		exec(r_word(FN_SLT, 5'd6, 5'd3, 5'd9));
		exec(r_word(FN_SLT, 5'd3, 5'd6, 5'd10));
		exec(mul_word(5'd3, 5'd3, 5'd11));
		exec(i_word(OP_ADDI, 5'd0, 5'd12, 16'h8000));
		exec(i_word(OP_SLTI, 5'd12, 5'd13, 16'h7fff));
		exec(i_word(OP_ANDI, 5'd1, 5'd14, 16'h8000));
		exec(i_word(OP_ADDI, 5'd1, 5'd0, 16'h0005));
		send_command(MODE_READ, $urandom(), 5'd0);
		exec(i_word(OP_BEQ, 5'd0, 5'd0, 16'h0002));
		exec(i_word(OP_BNE, 5'd0, 5'd0, 16'h8000));
		exec(i_word(OP_BNE, 5'd1, 5'd3, 16'hffff));
		exec(i_word(OP_ADDI, 5'd0, REG_A0, 16'hfffb));
		exec(i_word(OP_ORI, 5'd0, REG_V0, SYS_PRINT_INT[15:0]));
		exec(SYSCALL_WORD);
		exec(i_word(OP_ORI, 5'd0, REG_V0, SYS_PRINT_CHAR[15:0]));
		exec(SYSCALL_WORD);
	endtask

	// The core halts for good, so exactly one way of stopping it is exercised per run.
	task automatic drive_halting_sequence();
		halt_kind_t kind;
		logic [5:0] op;
		logic [15:0] off;
		logic [31:0] w;
		kind = halt_kind_t'($urandom_range(7));
		go_to_start();
		case (kind)
			HALT_EXIT: begin
				exec(i_word(OP_ORI, 5'd0, REG_V0, SYS_EXIT[15:0]));
				exec(SYSCALL_WORD);
			end
			HALT_UNKNOWN_SYS: begin
				exec(i_word(OP_LUI, 5'd0, REG_V0, random_imm()));
				exec(i_word(OP_ORI, REG_V0, REG_V0, 16'($urandom_range(65535, 12))));
				exec(SYSCALL_WORD);
			end
			HALT_INVALID: begin
				case ($urandom_range(4))
					0: begin
						op = 6'($urandom_range(63));
						while (op inside {OP_SPECIAL, OP_BEQ, OP_BNE, OP_ADDI, OP_SLTI, OP_ANDI,
								OP_ORI, OP_LUI, OP_SPECIAL2})
							op = 6'($urandom_range(63));
						w = $urandom();
						w[31:26] = op;
					end
					1: begin
						w = r_word(any_alu_funct(), 5'($urandom_range(31)),
							5'($urandom_range(31)), 5'($urandom_range(31)));
						w[10:6] = 5'($urandom_range(31, 1));
					end
					2: begin
						op = 6'($urandom_range(63));
						while (op inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT})
							op = 6'($urandom_range(63));
						w = r_word(op, 5'($urandom_range(31)), 5'($urandom_range(31)),
							5'($urandom_range(31)));
						if (w == SYSCALL_WORD) w[15:11] = 5'd1;
					end
					3: begin
						w = $urandom();
						w[31:26] = OP_SPECIAL2;
						while (w[10:0] == MUL_LOW_BITS) w[10:0] = 11'($urandom());
					end
					default: begin
						w = i_word(OP_LUI, 5'($urandom_range(31, 1)), 5'($urandom_range(31)),
							random_imm());
					end
				endcase
				exec(w);
			end
			HALT_BRANCH_OUT: begin
				if ($urandom_range(1)) off = 16'(-int'($urandom_range(32768, 1)));
				else off = 16'($urandom_range(32767, sb.limit()));
				exec(i_word(OP_BEQ, 5'd0, 5'd0, off));
			end
			HALT_FALL_OFF: begin
				write_length(LEN_W'(sb.pc + 1));
				exec(r_word(any_alu_funct(), 5'($urandom_range(31)), 5'($urandom_range(31)),
					5'($urandom_range(31, 1))));
			end
			HALT_PRINT_AT_END: begin
				exec(i_word(OP_ORI, 5'd0, REG_V0,
					$urandom_range(1) ? SYS_PRINT_INT[15:0] : SYS_PRINT_CHAR[15:0]));
				write_length(LEN_W'(sb.pc + 1));
				exec(SYSCALL_WORD);
			end
			HALT_PAST_LIMIT: begin
				repeat (3) exec(i_word(OP_ADDI, 5'($urandom_range(31)), 5'($urandom_range(31)),
					random_imm()));
				write_length(LEN_W'($urandom_range(sb.pc, 1)));
				exec($urandom());
			end
			default: begin
				write_length('0);
				exec($urandom());
			end
		endcase
		repeat (8) exec($urandom());
		for (int r = 0; r < NUM_REGS; r++) read_reg(5'(r));
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.mode = MODE_EXEC;
		cmd_bus.instruction_word = '0;
		cmd_bus.reg_index = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		no_idle = 1'b0;
		cycle_count = 0;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();
		write_length(11'h7ff);
		run_random(400);
		go_to_start();
		write_length(11'd1);
		run_random(30);
		go_to_start();
		write_length(11'd2);
		run_random(60);
		go_to_start();
		write_length(11'd37);
		run_random(300);
		write_length(11'd1024);
		no_idle = 1'b1;
		run_random(250);
		no_idle = 1'b0;
		run_random(350);
		drive_halting_sequence();

		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_outcomes.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (sb.errors == 0) begin
			$display("mips_subset_instruction_execute_tb: PASS");
		end else begin
			$display("mips_subset_instruction_execute_tb: FAIL");
		end
		$finish;
	end

endmodule
